// ----- rtl/pcd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants
// Particle entry layout, configuration set, action and register codes.
// ----------------------------------------------------------------------------
package pcd_pkg;

  localparam int PARTICLE_COUNT = 1024;
  localparam int IDX_W          = $clog2(PARTICLE_COUNT);

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CHECK = 2'd1,
    ACT_WRAP  = 2'd2,
    ACT_BEGIN = 2'd3
  } action_t;

  localparam logic [2:0] CFG_CUTOFF = 3'd0;
  localparam logic [2:0] CFG_ELIMIT = 3'd1;
  localparam logic [2:0] CFG_BOX_X  = 3'd2;
  localparam logic [2:0] CFG_BOX_Y  = 3'd3;
  localparam logic [2:0] CFG_BOX_Z  = 3'd4;
  localparam logic [2:0] CFG_WRAP   = 3'd5;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    logic [31:0] radius;
    logic [31:0] inv_mass;
    logic        active;
  } part_t;

  typedef struct packed {
    logic [31:0] cutoff_scale;
    logic [47:0] energy_limit;
    logic [31:0] box_x;
    logic [31:0] box_y;
    logic [31:0] box_z;
    logic [2:0]  wrap_axes;
  } cfg_t;

  typedef struct packed {
    logic done;
    logic contact;
    logic over;
  } calc_res_t;

endpackage

// ----- rtl/pcd_if.sv -----
// ----------------------------------------------------------------------------
// pcd_if: request channels
// Input request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pcd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [9:0]  index_a;
  logic [9:0]  index_b;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic [31:0] radius;
  logic [31:0] inv_mass;
  logic        active;

  modport source (output valid, action, index_a, index_b, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, radius, inv_mass, active, input ready);
  modport sink   (input valid, action, index_a, index_b, pos_x, pos_y, pos_z,
                  vel_x, vel_y, vel_z, radius, inv_mass, active, output ready);
endinterface

interface pcd_out_if;
  logic valid;
  logic ready;
  logic contact;
  logic over_limit;
  logic skipped;

  modport source (output valid, contact, over_limit, skipped, input ready);
  modport sink   (input valid, contact, over_limit, skipped, output ready);
endinterface

// ----- rtl/pcd_table.sv -----
// ----------------------------------------------------------------------------
// pcd_table: particle table
// One write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module pcd_table
  import pcd_pkg::*;
(
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  part_t            wdata,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr_a,
  input  logic [IDX_W-1:0] raddr_b,
  output part_t            rdata_a,
  output part_t            rdata_b
);

  part_t mem [PARTICLE_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/pcd_calc.sv -----
// ----------------------------------------------------------------------------
// pcd_calc: contact and energy sequencer
// Wrap displacement, then one shared 34x34 multiplier over ten steps.
// ----------------------------------------------------------------------------
module pcd_calc
  import pcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      wrapped,
  input  part_t     pa,
  input  part_t     pb,
  input  cfg_t      cfg,
  output calc_res_t res
);

  typedef enum logic [2:0] {C_IDLE, C_WRAP, C_MUL, C_DRAIN, C_EVAL} cstate_t;

  cstate_t            state_r;
  logic [3:0]         k_r;
  logic               pv_r;
  logic [3:0]         tag_r;
  logic [67:0]        prod_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic [2:0]         wen_r;
  logic [32:0]        mx_r, my_r, mz_r;
  logic [32:0]        rsum_r;
  logic [31:0]        vmx_r, vmy_r, vmz_r;
  logic [31:0]        im_r;
  logic [48:0]        reach_r;
  logic               big_r;
  logic [65:0]        dist_r;
  logic [67:0]        rr_r;
  logic [63:0]        v2_r;
  logic [79:0]        lim_r;
  logic [33:0]        opa, opb;
  logic [48:0]        lim1;
  logic               contact;
  logic               over;

  function automatic logic [32:0] wrap_mag(logic signed [32:0] d, logic [31:0] box,
                                           logic en);
    logic [32:0]        m;
    logic signed [33:0] w;
    m = d[32] ? 33'(-d) : 33'(d);
    w = $signed({2'b00, box}) - $signed({1'b0, m});
    if (en && (w < $signed({1'b0, m}))) begin
      return w[33] ? 33'(-w) : w[32:0];
    end
    return m;
  endfunction

  function automatic logic [31:0] vmag(logic [31:0] v);
    return v[31] ? 32'(-v) : v;
  endfunction

  assign lim1 = {1'b0, cfg.energy_limit} + 49'd1;

  always_comb begin
    case (k_r)
      4'd0:    begin opa = {1'b0, rsum_r};     opb = {2'b00, cfg.cutoff_scale}; end
      4'd1:    begin opa = {1'b0, mx_r};       opb = {1'b0, mx_r};              end
      4'd2:    begin opa = {1'b0, my_r};       opb = {1'b0, my_r};              end
      4'd3:    begin opa = {1'b0, mz_r};       opb = {1'b0, mz_r};              end
      4'd4:    begin opa = reach_r[33:0];      opb = reach_r[33:0];             end
      4'd5:    begin opa = {2'b00, vmx_r};     opb = {2'b00, vmx_r};            end
      4'd6:    begin opa = {2'b00, vmy_r};     opb = {2'b00, vmy_r};            end
      4'd7:    begin opa = {2'b00, vmz_r};     opb = {2'b00, vmz_r};            end
      4'd8:    begin opa = {2'b00, im_r};      opb = {2'b00, lim1[31:0]};       end
      4'd9:    begin opa = {2'b00, im_r};      opb = 34'(lim1[48:32]);          end
      default: begin opa = '0;                 opb = '0;                        end
    endcase
  end

  // contact: reach of 2^34 or more always beats the largest squared distance
  assign contact = big_r || ({2'b00, dist_r} < rr_r);
  assign over    = contact && ((im_r == 32'd0) ? (v2_r != 64'd0)
                                               : ({17'd0, v2_r} >= {lim_r, 1'b0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      k_r     <= '0;
      pv_r    <= 1'b0;
      res     <= '0;
    end else begin
      res  <= '0;
      pv_r <= 1'b0;
      case (state_r)
        C_IDLE: begin
          if (start) begin
            state_r <= C_WRAP;
          end
        end
        C_WRAP: begin
          k_r     <= '0;
          state_r <= C_MUL;
        end
        C_MUL: begin
          pv_r <= 1'b1;
          k_r  <= k_r + 4'd1;
          if (k_r == 4'd9) begin
            state_r <= C_DRAIN;
          end
        end
        C_DRAIN: begin
          state_r <= C_EVAL;
        end
        C_EVAL: begin
          res     <= '{done: 1'b1, contact: contact, over: over};
          state_r <= C_IDLE;
        end
        default: state_r <= C_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == C_IDLE && start) begin
      dx_r   <= $signed({pa.px[31], pa.px}) - $signed({pb.px[31], pb.px});
      dy_r   <= $signed({pa.py[31], pa.py}) - $signed({pb.py[31], pb.py});
      dz_r   <= $signed({pa.pz[31], pa.pz}) - $signed({pb.pz[31], pb.pz});
      wen_r  <= wrapped ? cfg.wrap_axes : 3'b000;
      rsum_r <= {1'b0, pa.radius} + {1'b0, pb.radius};
      vmx_r  <= vmag(pb.vx);
      vmy_r  <= vmag(pb.vy);
      vmz_r  <= vmag(pb.vz);
      im_r   <= pb.inv_mass;
    end
    if (state_r == C_WRAP) begin
      mx_r <= wrap_mag(dx_r, cfg.box_x, wen_r[0]);
      my_r <= wrap_mag(dy_r, cfg.box_y, wen_r[1]);
      mz_r <= wrap_mag(dz_r, cfg.box_z, wen_r[2]);
    end
    if (state_r == C_MUL) begin
      prod_r <= 68'(opa) * 68'(opb);
      tag_r  <= k_r;
    end
    if (pv_r) begin
      case (tag_r)
        4'd0: begin
          reach_r <= prod_r[64:16];
          big_r   <= |prod_r[64:50];
        end
        4'd1:    dist_r <= prod_r[65:0];
        4'd2,
        4'd3:    dist_r <= dist_r + prod_r[65:0];
        4'd4:    rr_r   <= prod_r;
        4'd5:    v2_r   <= prod_r[63:0];
        4'd6,
        4'd7:    v2_r   <= v2_r + prod_r[63:0];
        4'd8:    lim_r  <= 80'(prod_r);
        4'd9:    lim_r  <= lim_r + {prod_r[47:0], 32'd0};
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/pair_contact_energy_detector.sv -----
// ----------------------------------------------------------------------------
// pair_contact_energy_detector: pair contact and energy limit check
// Particle table in a dual-read memory, pair checks through a multiply
// sequencer, halt flag that blocks checks until a begin-pass request.
// ----------------------------------------------------------------------------
// Load and begin-pass requests give no result.
// A check request passes from acceptance to result through one table read,
// the wrap step, ten steps of the shared multiplier, drain and evaluate.
// Checks on a halted pass or an absent or inactive particle skip the
// sequencer. Reset (synchronous, active low) clears halt, control and the
// registers to their defaults; the table itself is not cleared.
module pair_contact_energy_detector
  import pcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  pcd_in_if.sink      in_ch,
  pcd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_CALC, S_OUT} state_t;

  state_t     state_r;
  logic       halted_r;
  cfg_t       cfg_r;
  logic       inr_r;
  logic       wrapped_r;
  logic       res_contact_r, res_over_r, res_skipped_r;
  logic       out_valid_r, out_contact_r, out_over_r, out_skipped_r;
  logic       accept;
  logic       is_check;
  logic       in_range_a, in_range_b;
  logic       tbl_we, tbl_re;
  part_t      wdata, rd_a, rd_b;
  logic       calc_start;
  calc_res_t  calc_res;

  // take a new request whenever idle, even while a result waits downstream
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_check    = (in_ch.action == ACT_CHECK) || (in_ch.action == ACT_WRAP);
  assign in_range_a  = 32'(in_ch.index_a) < PARTICLE_COUNT;
  assign in_range_b  = 32'(in_ch.index_b) < PARTICLE_COUNT;

  // drop loads outside the table
  assign tbl_we = accept && (in_ch.action == ACT_LOAD) && in_range_a;
  // reads start only on an unhalted check
  assign tbl_re = accept && is_check && !halted_r;

  assign wdata = '{px: in_ch.pos_x, py: in_ch.pos_y, pz: in_ch.pos_z,
                   vx: in_ch.vel_x, vy: in_ch.vel_y, vz: in_ch.vel_z,
                   radius: in_ch.radius, inv_mass: in_ch.inv_mass,
                   active: in_ch.active};

  pcd_table u_table (
    .clk     (clk),
    .we      (tbl_we),
    .waddr   (IDX_W'(in_ch.index_a)),
    .wdata   (wdata),
    .re      (tbl_re),
    .raddr_a (IDX_W'(in_ch.index_a)),
    .raddr_b (IDX_W'(in_ch.index_b)),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // hand the pair to the sequencer only when both ends exist and take part
  assign calc_start = (state_r == S_READ) && inr_r && rd_a.active && rd_b.active;

  pcd_calc u_calc (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (calc_start),
    .wrapped (wrapped_r),
    .pa      (rd_a),
    .pb      (rd_b),
    .cfg     (cfg_r),
    .res     (calc_res)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff_scale <= 32'h0001_0000;
      cfg_r.energy_limit <= '1;
      cfg_r.box_x        <= '0;
      cfg_r.box_y        <= '0;
      cfg_r.box_z        <= '0;
      cfg_r.wrap_axes    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CUTOFF: cfg_r.cutoff_scale <= cfg_data[31:0];
        CFG_ELIMIT: cfg_r.energy_limit <= cfg_data;
        CFG_BOX_X:  cfg_r.box_x        <= cfg_data[31:0];
        CFG_BOX_Y:  cfg_r.box_y        <= cfg_data[31:0];
        CFG_BOX_Z:  cfg_r.box_z        <= cfg_data[31:0];
        CFG_WRAP:   cfg_r.wrap_axes    <= cfg_data[2:0];
        default:    ;
      endcase
    end
  end

  // control sequence, halt flag and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      res_contact_r <= 1'b0;
      res_over_r    <= 1'b0;
      res_skipped_r <= 1'b0;
      inr_r         <= 1'b0;
      wrapped_r     <= 1'b0;
      out_contact_r <= 1'b0;
      out_over_r    <= 1'b0;
      out_skipped_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.action == ACT_BEGIN) begin
              halted_r <= 1'b0;
            end else if (is_check) begin
              inr_r     <= in_range_a && in_range_b;
              wrapped_r <= (in_ch.action == ACT_WRAP);
              if (halted_r) begin
                // halted pass: report skipped without touching the table
                res_contact_r <= 1'b0;
                res_over_r    <= 1'b0;
                res_skipped_r <= 1'b1;
                state_r       <= S_OUT;
              end else begin
                state_r <= S_READ;
              end
            end
          end
        end
        S_READ: begin
          if (calc_start) begin
            state_r <= S_CALC;
          end else begin
            res_contact_r <= 1'b0;
            res_over_r    <= 1'b0;
            res_skipped_r <= 1'b0;
            state_r       <= S_OUT;
          end
        end
        S_CALC: begin
          if (calc_res.done) begin
            res_contact_r <= calc_res.contact;
            res_over_r    <= calc_res.over;
            res_skipped_r <= 1'b0;
            if (calc_res.over) begin
              halted_r <= 1'b1;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r   <= 1'b1;
            out_contact_r <= res_contact_r;
            out_over_r    <= res_over_r;
            out_skipped_r <= res_skipped_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.contact    = out_contact_r;
  assign out_ch.over_limit = out_over_r;
  assign out_ch.skipped    = out_skipped_r;

  // the sequencer reports only while a check waits for it
  a_calc_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    calc_res.done |-> (state_r == S_CALC))
    else $error("sequencer result outside of a check");

  // over limit only with contact, skipped never with a check outcome
  a_out_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((!out_over_r || out_contact_r) &&
                     (!out_skipped_r || (!out_contact_r && !out_over_r))))
    else $error("inconsistent result fields");

  // a check on a halted pass goes straight to a skipped result
  a_halt_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_check && halted_r) |=> ((state_r == S_OUT) && res_skipped_r))
    else $error("halted pass did not skip");

  // table reads happen only on an accepted check
  a_read_on_check: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_re |=> (state_r == S_READ))
    else $error("table read without a check");

endmodule
